@@ rtl/sfd_pkg.sv @@
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int BYTE_W = 8;
  localparam int PAIR_W = 17;
  localparam int LEN_W = 13;
  localparam int EVENT_W = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = PAIR_W;
  localparam int PAIR_REGS = 4;
  localparam int LEN_FIELD_MAX = 8191;

  localparam int DEFAULT_MAX_FRAME_LEN = 4096;
  localparam int DEFAULT_ESCAPE_PAIRS = 4;

  localparam int PAIR_VALID_BIT = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_BYTE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_BYTE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAIR_A = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PAIR_B = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PAIR_C = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PAIR_D = 3'd6;

  localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hC0;
  localparam logic [BYTE_W-1:0] END_BYTE_RESET = 8'hC0;
  localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RESET = 8'hDB;
  localparam logic [PAIR_W-1:0] PAIR_A_RESET = 17'h1C0DC;
  localparam logic [PAIR_W-1:0] PAIR_B_RESET = 17'h1DBDD;
  localparam logic [PAIR_W-1:0] PAIR_C_RESET = 17'h00000;
  localparam logic [PAIR_W-1:0] PAIR_D_RESET = 17'h00000;

  localparam logic [EVENT_W-1:0] EV_DATA = 2'd0;
  localparam logic [EVENT_W-1:0] EV_END = 2'd1;
  localparam logic [EVENT_W-1:0] EV_ABORT = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [PAIR_REGS-1:0][PAIR_W-1:0] pair;
  } sfd_cfg_t;

  typedef struct packed {
    logic valid;
    logic [EVENT_W-1:0] event_code;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0] frame_length;
    logic length_overflow;
  } sfd_result_t;

endpackage

@@ rtl/sfd_cfg.sv @@
`timescale 1ns / 1ps

module sfd_cfg
  import sfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output sfd_cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= START_BYTE_RESET;
      cfg.end_byte <= END_BYTE_RESET;
      cfg.escape_byte <= ESCAPE_BYTE_RESET;
      cfg.pair[0] <= PAIR_A_RESET;
      cfg.pair[1] <= PAIR_B_RESET;
      cfg.pair[2] <= PAIR_C_RESET;
      cfg.pair[3] <= PAIR_D_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE: cfg.start_byte <= cfg_data[BYTE_W-1:0];
        REG_END_BYTE: cfg.end_byte <= cfg_data[BYTE_W-1:0];
        REG_ESCAPE_BYTE: cfg.escape_byte <= cfg_data[BYTE_W-1:0];
        REG_PAIR_A: cfg.pair[0] <= cfg_data[PAIR_W-1:0];
        REG_PAIR_B: cfg.pair[1] <= cfg_data[PAIR_W-1:0];
        REG_PAIR_C: cfg.pair[2] <= cfg_data[PAIR_W-1:0];
        REG_PAIR_D: cfg.pair[3] <= cfg_data[PAIR_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/sfd_decode.sv @@
`timescale 1ns / 1ps

module sfd_decode
  import sfd_pkg::*;
#(
  parameter int MAX_FRAME_LEN = DEFAULT_MAX_FRAME_LEN,
  parameter int ESCAPE_PAIRS = DEFAULT_ESCAPE_PAIRS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  input  sfd_cfg_t          cfg,
  output sfd_result_t       res
);

  localparam int LIMIT_INT = (MAX_FRAME_LEN < LEN_FIELD_MAX) ? MAX_FRAME_LEN : LEN_FIELD_MAX;
  localparam logic [LEN_W-1:0] COUNT_LIMIT = LEN_W'(LIMIT_INT);
  localparam int NUM_PAIRS = (ESCAPE_PAIRS < PAIR_REGS) ? ESCAPE_PAIRS : PAIR_REGS;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_ESC = 2'd2;

  logic [1:0]       mode;
  logic [1:0]       mode_next;
  logic [LEN_W-1:0] byte_count;
  logic [LEN_W-1:0] byte_count_next;
  logic             overflow_seen;
  logic             overflow_seen_next;
  logic             pair_hit;
  logic [BYTE_W-1:0] pair_byte;
  logic             count_one;
  logic             clear_count;

  always_comb begin
    pair_hit = 1'b0;
    pair_byte = '0;
    for (int i = NUM_PAIRS - 1; i >= 0; i--) begin
      if (cfg.pair[i][PAIR_VALID_BIT] && (cfg.pair[i][BYTE_W-1:0] == rx_byte)) begin
        pair_hit = 1'b1;
        pair_byte = cfg.pair[i][2*BYTE_W-1:BYTE_W];
      end
    end
  end

  always_comb begin
    res = '0;
    mode_next = mode;
    count_one = 1'b0;
    clear_count = 1'b0;
    case (mode)
      MODE_FRAME: begin
        if (rx_byte == cfg.end_byte) begin
          res.valid = 1'b1;
          res.event_code = EV_END;
          res.frame_length = byte_count;
          res.length_overflow = overflow_seen;
          mode_next = MODE_IDLE;
        end else if (rx_byte == cfg.start_byte) begin
          res.valid = 1'b1;
          res.event_code = EV_ABORT;
          res.data_byte = rx_byte;
          clear_count = 1'b1;
          mode_next = MODE_IDLE;
        end else if (rx_byte == cfg.escape_byte) begin
          mode_next = MODE_ESC;
        end else begin
          res.valid = 1'b1;
          res.event_code = EV_DATA;
          res.data_byte = rx_byte;
          count_one = 1'b1;
        end
      end
      MODE_ESC: begin
        res.valid = 1'b1;
        if (pair_hit) begin
          res.event_code = EV_DATA;
          res.data_byte = pair_byte;
          count_one = 1'b1;
          mode_next = MODE_FRAME;
        end else begin
          res.event_code = EV_ABORT;
          res.data_byte = rx_byte;
          clear_count = 1'b1;
          mode_next = MODE_IDLE;
        end
      end
      default: begin
        if (rx_byte == cfg.start_byte) begin
          clear_count = 1'b1;
          mode_next = MODE_FRAME;
        end else begin
          mode_next = MODE_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    byte_count_next = byte_count;
    overflow_seen_next = overflow_seen;
    if (clear_count) begin
      byte_count_next = '0;
      overflow_seen_next = 1'b0;
    end else if (count_one) begin
      if (byte_count < COUNT_LIMIT) begin
        byte_count_next = byte_count + LEN_W'(1);
      end else begin
        overflow_seen_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      byte_count <= '0;
      overflow_seen <= 1'b0;
    end else if (step) begin
      mode <= mode_next;
      byte_count <= byte_count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_LIMIT)
    else $error("frame byte count passed its bound");

  a_overflow_at_limit: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (byte_count == COUNT_LIMIT))
    else $error("overflow flag set below the length bound");

  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid && (res.event_code == EV_END)) |=> (mode == MODE_IDLE))
    else $error("decoder did not return to idle after frame end");

  a_abort_clears: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid && (res.event_code == EV_ABORT))
      |=> (mode == MODE_IDLE) && (byte_count == '0) && !overflow_seen)
    else $error("abort did not clear the frame state");

endmodule

@@ rtl/sfd_result_reg.sv @@
`timescale 1ns / 1ps

module sfd_result_reg
  import sfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  sfd_result_t        res,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [EVENT_W-1:0] event_code,
  output logic [BYTE_W-1:0]  data_byte,
  output logic [LEN_W-1:0]   frame_length,
  output logic               length_overflow
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_code <= res.event_code;
      data_byte <= res.data_byte;
      frame_length <= res.frame_length;
      length_overflow <= res.length_overflow;
    end
  end

endmodule

@@ rtl/slip_frame_decoder.sv @@
`timescale 1ns / 1ps

// Byte-stream frame decoder. Line bytes enter on the rx channel (in_valid, in_stall,
// rx_byte), one request per byte. Decoded requests leave on the out channel
// (out_valid, out_stall) as data bytes, frame ends with length and overflow flag,
// or aborts carrying the offending byte. Bytes outside a frame, the opening
// byte and escape introducers produce no output request.
// A byte accepted into the input register is decoded from there, and its result,
// if any, is loaded into the output register once the output is not stalled, which
// raises out_valid. One byte is taken every cycle while the output is
// drained; the single decode step between the two registers sets this rate.
// When the receiver stalls with a result held, the input register keeps its byte
// and in_stall is raised until the result is taken.
// Reset clears the decode state and both valid flags and loads the default framing
// bytes and escape pairs. The configuration port writes a register per cycle and
// should be used only while no byte is in flight.
module slip_frame_decoder
  import sfd_pkg::*;
#(
  parameter int MAX_FRAME_LEN = DEFAULT_MAX_FRAME_LEN,
  parameter int ESCAPE_PAIRS = DEFAULT_ESCAPE_PAIRS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [BYTE_W-1:0]      rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [EVENT_W-1:0]     event_code,
  output logic [BYTE_W-1:0]      data_byte,
  output logic [LEN_W-1:0]       frame_length,
  output logic                   length_overflow
);

  sfd_cfg_t          cfg;
  sfd_result_t       res;
  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  logic              advance;

  assign in_stall = held_valid && out_valid && out_stall;
  assign advance = held_valid && !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= rx_byte;
    end
  end

  sfd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfd_decode #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN),
    .ESCAPE_PAIRS  (ESCAPE_PAIRS)
  ) u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (held_byte),
    .cfg     (cfg),
    .res     (res)
  );

  sfd_result_reg u_result (
    .clk             (clk),
    .rst             (rst),
    .load            (advance && res.valid),
    .res             (res),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .event_code      (event_code),
    .data_byte       (data_byte),
    .frame_length    (frame_length),
    .length_overflow (length_overflow)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import sfd_pkg::*;

  localparam int FRAME_BOUND = (DEFAULT_MAX_FRAME_LEN < LEN_FIELD_MAX) ?
                               DEFAULT_MAX_FRAME_LEN : LEN_FIELD_MAX;
  localparam int LIVE_PAIRS = (DEFAULT_ESCAPE_PAIRS < PAIR_REGS) ?
                              DEFAULT_ESCAPE_PAIRS : PAIR_REGS;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 4;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_FRAME,
    MODE_ESC
  } decode_mode_e;

  typedef struct packed {
    logic [EVENT_W-1:0] code;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0] length;
    logic ovf;
  } frame_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [EVENT_W-1:0] event_code;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0] frame_length;
  logic length_overflow;

  sfd_cfg_t model_cfg;
  decode_mode_e model_mode = MODE_IDLE;
  logic [LEN_W-1:0] model_count = '0;
  logic model_ovf = 1'b0;
  frame_event_t pending_events[$];

  bit idle_on = 1'b1;
  bit stall_on = 1'b1;
  int hold_cycles = 0;
  int failures = 0;
  int n_data = 0;
  int n_end = 0;
  int n_abort = 0;
  int n_overflow = 0;
  int n_phases = 0;

  slip_frame_decoder #(
    .MAX_FRAME_LEN(DEFAULT_MAX_FRAME_LEN),
    .ESCAPE_PAIRS(DEFAULT_ESCAPE_PAIRS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_code(event_code),
    .data_byte(data_byte),
    .frame_length(frame_length),
    .length_overflow(length_overflow)
  );

  always #10 clk = ~clk;

  function automatic void bump_count();
    if (model_count < FRAME_BOUND) begin
      model_count = model_count + 1'b1;
    end else begin
      model_ovf = 1'b1;
    end
  endfunction

  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    frame_event_t ev;
    logic emit;
    logic hit;
    ev = '0;
    emit = 1'b0;
    hit = 1'b0;
    case (model_mode)
      MODE_FRAME: begin
        if (b == model_cfg.end_byte) begin
          ev.code = EV_END;
          ev.length = model_count;
          ev.ovf = model_ovf;
          model_mode = MODE_IDLE;
          emit = 1'b1;
        end else if (b == model_cfg.start_byte) begin
          ev.code = EV_ABORT;
          ev.data = b;
          model_count = '0;
          model_ovf = 1'b0;
          model_mode = MODE_IDLE;
          emit = 1'b1;
        end else if (b == model_cfg.escape_byte) begin
          model_mode = MODE_ESC;
        end else begin
          bump_count();
          ev.code = EV_DATA;
          ev.data = b;
          emit = 1'b1;
        end
      end
      MODE_ESC: begin
        for (int i = 0; i < LIVE_PAIRS; i++) begin
          if (!hit && model_cfg.pair[i][PAIR_VALID_BIT] && model_cfg.pair[i][7:0] == b) begin
            hit = 1'b1;
            ev.data = model_cfg.pair[i][15:8];
          end
        end
        emit = 1'b1;
        if (hit) begin
          bump_count();
          ev.code = EV_DATA;
          model_mode = MODE_FRAME;
        end else begin
          ev.code = EV_ABORT;
          ev.data = b;
          model_count = '0;
          model_ovf = 1'b0;
          model_mode = MODE_IDLE;
        end
      end
      default: begin
        if (b == model_cfg.start_byte) begin
          model_count = '0;
          model_ovf = 1'b0;
          model_mode = MODE_FRAME;
        end else begin
          model_mode = MODE_IDLE;
        end
      end
    endcase
    if (emit) begin
      pending_events.push_back(ev);
    end
  endfunction

  always @(posedge clk) begin
    frame_event_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $error("Unexpected request: event_code %0d data_byte %h", event_code, data_byte);
          failures++;
        end else begin
          want = pending_events.pop_front();
          if (event_code !== want.code) begin
            $error("event_code: expected %0d, actual %0d", want.code, event_code);
            failures++;
          end
          if (data_byte !== want.data) begin
            $error("data_byte: expected %h, actual %h", want.data, data_byte);
            failures++;
          end
          if (frame_length !== want.length) begin
            $error("frame_length: expected %0d, actual %0d", want.length, frame_length);
            failures++;
          end
          if (length_overflow !== want.ovf) begin
            $error("length_overflow: expected %0d, actual %0d", want.ovf, length_overflow);
            failures++;
          end
          case (want.code)
            EV_DATA: n_data++;
            EV_END: begin
              n_end++;
              if (want.ovf) begin
                n_overflow++;
              end
            end
            default: n_abort++;
          endcase
        end
      end
      if (in_valid && !in_stall) begin
        decode_byte(rx_byte);
      end
    end
  end

  // The receiver waits a drawn number of cycles before each request, or a long
  // hold-off when one has been asked for.
  initial begin : receiver
    int wait_n;
    forever begin
      wait_n = stall_on ? int'($urandom_range(0, 3)) : 0;
      if (hold_cycles > 0) begin
        wait_n = hold_cycles;
        hold_cycles = 0;
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = idle_on ? int'($urandom_range(0, 3)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Byte registers are written with junk in the upper bits, which must be masked.
  task automatic load_config(input sfd_cfg_t c);
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] junk;
    settle();
    for (int r = 0; r <= int'(REG_UNUSED); r++) begin
      idx = r[CFG_INDEX_W-1:0];
      junk = CFG_DATA_W'($urandom);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      case (idx)
        REG_START_BYTE: cfg_data <= {junk[16:8], c.start_byte};
        REG_END_BYTE: cfg_data <= {junk[16:8], c.end_byte};
        REG_ESCAPE_BYTE: cfg_data <= {junk[16:8], c.escape_byte};
        REG_PAIR_A: cfg_data <= c.pair[0];
        REG_PAIR_B: cfg_data <= c.pair[1];
        REG_PAIR_C: cfg_data <= c.pair[2];
        REG_PAIR_D: cfg_data <= c.pair[3];
        default: cfg_data <= junk;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    model_cfg = c;
    n_phases++;
  endtask

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom); while (b == model_cfg.start_byte || b == model_cfg.end_byte ||
                                     b == model_cfg.escape_byte);
    return b;
  endfunction

  // Sends n decoded bytes as a mix of plain bytes and escape sequences that hit a pair.
  task automatic send_body(input int n);
    int live[$];
    int pick;
    live = {};
    for (int i = 0; i < LIVE_PAIRS; i++) begin
      if (model_cfg.pair[i][PAIR_VALID_BIT]) begin
        live.push_back(i);
      end
    end
    for (int k = 0; k < n; k++) begin
      if (live.size() != 0 && $urandom_range(0, 5) == 0) begin
        pick = live[$urandom_range(0, live.size() - 1)];
        send_byte(model_cfg.escape_byte);
        send_byte(model_cfg.pair[pick][7:0]);
      end else begin
        send_byte(plain_byte());
      end
    end
  endtask

  task automatic send_frame(input int n, input bit clean);
    send_byte(model_cfg.start_byte);
    send_body(n);
    if (!clean) begin
      case ($urandom_range(0, 3))
        0: send_byte(model_cfg.start_byte);
        1: begin
          send_byte(model_cfg.escape_byte);
          send_byte(BYTE_W'($urandom));
        end
        2: send_byte(BYTE_W'($urandom));
        default: send_body(2);
      endcase
    end
    send_byte(model_cfg.end_byte);
  endtask

  task automatic test_reset_defaults();
    logic [BYTE_W-1:0] seq[$];
    seq = {8'h00, 8'hFF, 8'hDB, 8'hDC,
           8'hC0, 8'h00, 8'hFF, 8'hDB, 8'hDC, 8'hDB, 8'hDD, 8'h7F, 8'hC0,
           8'hC0, 8'hC0,
           8'hC0, 8'h55, 8'hDB, 8'h01, 8'h55,
           8'hC0, 8'hDB, 8'hDB};
    foreach (seq[i]) begin
      send_byte(seq[i]);
    end
    settle();
  endtask

  task automatic test_framing_cases();
    sfd_cfg_t c;
    logic [BYTE_W-1:0] seq[$];
    c.start_byte = 8'h7E;
    c.end_byte = 8'h7D;
    c.escape_byte = 8'h7C;
    c.pair[0] = {1'b1, 8'h7E, 8'h11};
    c.pair[1] = {1'b1, 8'h22, 8'h11};
    c.pair[2] = {1'b0, 8'h55, 8'h33};
    c.pair[3] = {1'b1, 8'h7C, 8'h44};
    load_config(c);
    seq = {8'h7E, 8'h01, 8'h7C, 8'h11, 8'h7C, 8'h44, 8'h7D,
           8'h7E, 8'h7C, 8'h33,
           8'h7E, 8'h02, 8'h7E, 8'h02,
           8'h7E, 8'h7D};
    foreach (seq[i]) begin
      send_byte(seq[i]);
    end
    settle();
  endtask

  task automatic test_length_bound();
    sfd_cfg_t c;
    c.start_byte = START_BYTE_RESET;
    c.end_byte = 8'hC1;
    c.escape_byte = ESCAPE_BYTE_RESET;
    c.pair = {PAIR_D_RESET, PAIR_C_RESET, PAIR_B_RESET, PAIR_A_RESET};
    load_config(c);
    idle_on = 1'b0;
    send_frame(FRAME_BOUND + 1, 1'b1);
    send_frame(3, 1'b1);
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    idle_on = 1'b0;
    hold_cycles = 60;
    send_frame(40, 1'b1);
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    sfd_cfg_t c;
    int sent;
    int n;
    sent = 0;
    for (int ph = 0; sent < 1400; ph++) begin
      case (ph)
        0: c = '0;
        1: begin
          c.start_byte = '1;
          c.end_byte = '1;
          c.escape_byte = '1;
          c.pair = '1;
        end
        default: begin
          c.start_byte = BYTE_W'($urandom);
          c.end_byte = ($urandom_range(0, 2) == 0) ? c.start_byte : 8'($urandom);
          c.escape_byte = BYTE_W'($urandom);
          for (int i = 0; i < PAIR_REGS; i++) begin
            c.pair[i] = {($urandom_range(0, 4) != 0), 16'($urandom)};
          end
          if ($urandom_range(0, 2) == 0) begin
            c.pair[1][7:0] = c.pair[0][7:0];
          end
        end
      endcase
      load_config(c);
      idle_on = (ph % 4) != 3;
      stall_on = (ph % 4) != 3;
      for (int f = 0; f < 12; f++) begin
        repeat ($urandom_range(0, 2)) send_byte(BYTE_W'($urandom));
        n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 60)) :
                                          int'($urandom_range(0, 10));
        send_frame(n, $urandom_range(0, 4) != 0);
        sent += n + 2;
      end
    end
    settle();
    idle_on = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    model_cfg.start_byte = START_BYTE_RESET;
    model_cfg.end_byte = END_BYTE_RESET;
    model_cfg.escape_byte = ESCAPE_BYTE_RESET;
    model_cfg.pair = {PAIR_D_RESET, PAIR_C_RESET, PAIR_B_RESET, PAIR_A_RESET};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_framing_cases();
    test_length_bound();
    test_output_backpressure();
    test_random_traffic();
    settle();
    $display("Checked %0d data bytes, %0d frame ends (%0d over the length bound), %0d aborts.",
             n_data, n_end, n_overflow, n_abort);
    $display("Register settings used: %0d, including all-zero and all-ones values.", n_phases);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d requests still expected.", pending_events.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
